// File: rtl/leg_command_text_parser_macros.svh
// Assertion macros shared by the parser RTL.
// Both macros sample on clk and are switched off while rst is high.
`ifndef LEG_COMMAND_TEXT_PARSER_MACROS_SVH
`define LEG_COMMAND_TEXT_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LCP_ASSERT_IMPLY(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("parser check failed");

`define LCP_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("parser check failed");

`else

`define LCP_ASSERT_IMPLY(label, cond, expr)

`define LCP_ASSERT_NEXT(label, cond, expr)

`endif

`endif

// File: rtl/lcp_pkg.sv
package lcp_pkg;

  localparam int FRACTION_DIGITS = 4;
  localparam int VALUE_BITS      = 24;
  localparam int FC_W            = $clog2(FRACTION_DIGITS + 1);
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  localparam logic [VALUE_BITS-1:0] POSITION_LIMIT_RESET = VALUE_BITS'(2000);
  localparam logic [VALUE_BITS-1:0] POWER_LIMIT_RESET    = VALUE_BITS'(10000);
  localparam logic [VALUE_BITS-1:0] DEFAULT_RATE_RESET   = VALUE_BITS'(5000);

  // Configuration register indexes.
  localparam logic [1:0] REG_POSITION_LIMIT = 2'd0;
  localparam logic [1:0] REG_POWER_LIMIT    = 2'd1;
  localparam logic [1:0] REG_DEFAULT_RATE   = 2'd2;

  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_RATE  = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_INFO  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_ORDER    = 3'd1,
    ERR_LEG      = 3'd2,
    ERR_ACTUATOR = 3'd3,
    ERR_HASH     = 3'd4,
    ERR_NUMBER   = 3'd5,
    ERR_POSITION = 3'd6,
    ERR_POWER    = 3'd7
  } err_t;

  // One received character, already sorted into the classes the parser needs.
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_dot;
    logic       is_hash;
    logic       is_nl;
    logic       is_l;
    logic       is_p;
    logic       is_s;
    logic       is_i;
  } cls_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] position_limit;
    logic [VALUE_BITS-1:0] power_limit;
    logic [VALUE_BITS-1:0] default_rate;
  } cfg_t;

  typedef struct packed {
    kind_t                 kind;
    logic [2:0]            leg;
    logic [1:0]            actuator;
    logic [VALUE_BITS-1:0] position;
    logic                  position_given;
    logic [VALUE_BITS-1:0] power;
    logic                  power_given;
    logic [VALUE_BITS-1:0] rate;
    err_t                  err;
  } result_t;

  // Weight of a digit n places left of the last kept fraction digit.
  function automatic logic [VALUE_BITS-1:0] pow10(input logic [FC_W-1:0] n);
    logic [VALUE_BITS-1:0] p;
    logic [VALUE_BITS-1:0] r;
    p = VALUE_BITS'(1);
    r = VALUE_BITS'(1);
    for (int i = 0; i <= FRACTION_DIGITS; i++) begin
      if (n == FC_W'(i)) begin
        r = p;
      end
      p = VALUE_BITS'(p * VALUE_BITS'(10));
    end
    return r;
  endfunction

endpackage

// File: rtl/lcp_front.sv
module lcp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    byte_in,
  output logic          fr_valid,
  input  logic          fr_ready,
  output lcp_pkg::cls_t fr_cls
);

  logic          slot_valid;
  logic          slot_valid_next;
  lcp_pkg::cls_t slot;
  lcp_pkg::cls_t cls;

  always_comb begin
    cls          = '0;
    cls.is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
    cls.digit    = byte_in[3:0];
    cls.is_dot   = (byte_in == 8'h2E);
    cls.is_hash  = (byte_in == 8'h23);
    cls.is_nl    = (byte_in == 8'h0A);
    cls.is_l     = (byte_in == 8'h4C);
    cls.is_p     = (byte_in == 8'h50);
    cls.is_s     = (byte_in == 8'h53);
    cls.is_i     = (byte_in == 8'h49);
  end

  assign in_ready = !slot_valid || fr_ready;
  assign fr_valid = slot_valid;
  assign fr_cls   = slot;

  always_comb begin
    slot_valid_next = slot_valid;
    if (in_valid && in_ready) begin
      slot_valid_next = 1'b1;
    end else if (fr_ready) begin
      slot_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot <= cls;
    end
  end

endmodule

// File: rtl/lcp_queue.sv
module lcp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  lcp_pkg::cls_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lcp_pkg::cls_t pop_data
);

  localparam int PTR_W = (lcp_pkg::QUEUE_DEPTH > 1) ? $clog2(lcp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lcp_pkg::QUEUE_DEPTH + 1);

  lcp_pkg::cls_t    mem [lcp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(lcp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(lcp_pkg::QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + CNT_W'(1));
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/lcp_back.sv
module lcp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  lcp_pkg::cls_t    q_cls,
  input  lcp_pkg::cfg_t    cfg,
  output logic             out_valid,
  input  logic             out_ready,
  output lcp_pkg::result_t result
);

  localparam int VB = lcp_pkg::VALUE_BITS;
  localparam int FC = lcp_pkg::FC_W;

  typedef enum logic [8:0] {
    IDLE    = 9'b000000001,
    SKIP    = 9'b000000010,
    LEG     = 9'b000000100,
    ACT     = 9'b000001000,
    POSHASH = 9'b000010000,
    POS     = 9'b000100000,
    PWR     = 9'b001000000,
    PHASH   = 9'b010000000,
    RATE    = 9'b100000000
  } mode_t;

  mode_t            mode, mode_next;
  logic [VB-1:0]    acc, acc_next;
  logic [FC-1:0]    frac_cnt, frac_cnt_next;
  logic             dot_seen, dot_seen_next;
  logic             frozen, frozen_next;
  logic             nonempty, nonempty_next;
  logic [2:0]       held_leg, held_leg_next;
  logic [1:0]       held_act, held_act_next;
  logic [VB-1:0]    held_pos, held_pos_next;
  logic             held_pos_given, held_pos_given_next;
  logic             out_valid_next;
  lcp_pkg::result_t res_next;

  logic             step;
  logic             emit;
  logic             err;
  lcp_pkg::err_t    err_code;
  logic [VB+3:0]    prod;
  logic [VB-1:0]    int_base;
  logic [VB:0]      int_add;
  logic [VB:0]      int_sum;
  logic [VB:0]      frac_add;
  logic [VB:0]      frac_sum;
  logic [VB-1:0]    int_val;
  logic [VB-1:0]    frac_val;
  logic [FC-1:0]    frac_pos;

  // A queued character is processed whenever the output register can take a result.
  assign step    = q_valid && (!out_valid || out_ready);
  assign q_ready = !out_valid || out_ready;

  // Integer digit: saturate the times-ten, then add the digit at full weight and saturate.
  assign prod     = (VB+4)'({acc, 3'b000}) + (VB+4)'({acc, 1'b0});
  assign int_base = (prod > (VB+4)'(lcp_pkg::VALUE_MAX)) ? lcp_pkg::VALUE_MAX : prod[VB-1:0];
  assign int_add  = (VB+1)'(q_cls.digit) *
                    (VB+1)'(lcp_pkg::pow10(FC'(lcp_pkg::FRACTION_DIGITS)));
  assign int_sum  = (VB+1)'(int_base) + int_add;
  assign int_val  = int_sum[VB] ? lcp_pkg::VALUE_MAX : int_sum[VB-1:0];

  assign frac_pos = FC'(FC'(lcp_pkg::FRACTION_DIGITS - 1) - frac_cnt);
  assign frac_add = (VB+1)'(q_cls.digit) * (VB+1)'(lcp_pkg::pow10(frac_pos));
  assign frac_sum = (VB+1)'(acc) + frac_add;
  assign frac_val = frac_sum[VB] ? lcp_pkg::VALUE_MAX : frac_sum[VB-1:0];

  always_comb begin
    mode_next           = mode;
    acc_next            = acc;
    frac_cnt_next       = frac_cnt;
    dot_seen_next       = dot_seen;
    frozen_next         = frozen;
    nonempty_next       = nonempty;
    held_leg_next       = held_leg;
    held_act_next       = held_act;
    held_pos_next       = held_pos;
    held_pos_given_next = held_pos_given;
    res_next            = '0;
    emit                = 1'b0;
    err                 = 1'b0;
    err_code            = lcp_pkg::ERR_NONE;

    case (mode)
      IDLE: begin
        if (q_cls.is_l) begin
          mode_next = LEG;
        end else if (q_cls.is_p) begin
          mode_next = PHASH;
        end else if (q_cls.is_s || q_cls.is_i) begin
          emit          = 1'b1;
          res_next.kind = q_cls.is_s ? lcp_pkg::KIND_STOP : lcp_pkg::KIND_INFO;
          mode_next     = SKIP;
        end else begin
          err      = 1'b1;
          err_code = lcp_pkg::ERR_ORDER;
        end
      end
      SKIP: begin
        if (q_cls.is_nl) begin
          mode_next = IDLE;
        end
      end
      LEG: begin
        if (q_cls.is_digit && q_cls.digit >= 4'd1 && q_cls.digit <= 4'd4) begin
          held_leg_next = q_cls.digit[2:0];
          mode_next     = ACT;
        end else begin
          err      = 1'b1;
          err_code = lcp_pkg::ERR_LEG;
        end
      end
      ACT: begin
        if (q_cls.is_digit && q_cls.digit >= 4'd1 && q_cls.digit <= 4'd3) begin
          held_act_next = q_cls.digit[1:0];
          mode_next     = POSHASH;
        end else begin
          err      = 1'b1;
          err_code = lcp_pkg::ERR_ACTUATOR;
        end
      end
      POSHASH, PHASH: begin
        if (q_cls.is_hash) begin
          acc_next      = '0;
          frac_cnt_next = '0;
          dot_seen_next = 1'b0;
          frozen_next   = 1'b0;
          nonempty_next = 1'b0;
          mode_next     = (mode == POSHASH) ? POS : RATE;
        end else begin
          err      = 1'b1;
          err_code = lcp_pkg::ERR_HASH;
        end
      end
      POS, PWR, RATE: begin
        if (!q_cls.is_hash) begin
          if (q_cls.is_dot) begin
            nonempty_next = 1'b1;
            dot_seen_next = 1'b1;
            frozen_next   = frozen || dot_seen;
          end else if (q_cls.is_digit) begin
            nonempty_next = 1'b1;
            if (!frozen) begin
              if (!dot_seen) begin
                acc_next = int_val;
              end else if (frac_cnt < FC'(lcp_pkg::FRACTION_DIGITS)) begin
                acc_next      = frac_val;
                frac_cnt_next = FC'(frac_cnt + FC'(1));
              end
            end
          end else begin
            err      = 1'b1;
            err_code = lcp_pkg::ERR_NUMBER;
          end
        end else if (mode == POS) begin
          if (nonempty && acc > cfg.position_limit) begin
            err      = 1'b1;
            err_code = lcp_pkg::ERR_POSITION;
          end else begin
            held_pos_next       = nonempty ? acc : '0;
            held_pos_given_next = nonempty;
            acc_next            = '0;
            frac_cnt_next       = '0;
            dot_seen_next       = 1'b0;
            frozen_next         = 1'b0;
            nonempty_next       = 1'b0;
            mode_next           = PWR;
          end
        end else if (mode == PWR) begin
          if (nonempty && acc > cfg.power_limit) begin
            err      = 1'b1;
            err_code = lcp_pkg::ERR_POWER;
          end else begin
            emit                    = 1'b1;
            res_next.kind           = lcp_pkg::KIND_MOVE;
            res_next.leg            = held_leg;
            res_next.actuator       = held_act;
            res_next.position       = held_pos;
            res_next.position_given = held_pos_given;
            res_next.power          = nonempty ? acc : '0;
            res_next.power_given    = nonempty;
            mode_next               = SKIP;
          end
        end else begin
          emit          = 1'b1;
          res_next.kind = lcp_pkg::KIND_RATE;
          res_next.rate = nonempty ? acc : cfg.default_rate;
          mode_next     = SKIP;
        end
      end
      default: begin
        mode_next = IDLE;
      end
    endcase

    // A newline that causes an error also ends the line, so no skip follows.
    if (err) begin
      emit          = 1'b1;
      res_next      = '0;
      res_next.kind = lcp_pkg::KIND_ERROR;
      res_next.err  = err_code;
      mode_next     = q_cls.is_nl ? IDLE : SKIP;
    end
  end

  always_comb begin
    if (step) begin
      out_valid_next = emit;
    end else begin
      out_valid_next = out_valid && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= IDLE;
      acc            <= '0;
      frac_cnt       <= '0;
      dot_seen       <= 1'b0;
      frozen         <= 1'b0;
      nonempty       <= 1'b0;
      held_leg       <= '0;
      held_act       <= '0;
      held_pos       <= '0;
      held_pos_given <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (step) begin
        mode           <= mode_next;
        acc            <= acc_next;
        frac_cnt       <= frac_cnt_next;
        dot_seen       <= dot_seen_next;
        frozen         <= frozen_next;
        nonempty       <= nonempty_next;
        held_leg       <= held_leg_next;
        held_act       <= held_act_next;
        held_pos       <= held_pos_next;
        held_pos_given <= held_pos_given_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result <= res_next;
    end
  end

endmodule

// File: rtl/leg_command_text_parser.sv
// Text command parser for leg actuator control.
// Input channel: one ASCII character per transfer on byte_in (in_valid/in_ready).
// Output channel: one event per transfer (out_valid/out_ready). Commands are
// "L<leg><act>#pos#power#", "P#rate#", "S" and "I"; everything after a finished
// command up to the next newline is ignored. Bad characters, range failures and
// syntax errors give an error event and the rest of the line is dropped.
// Configuration: cfg_write with cfg_index selects position limit (0), power
// limit (1) or default rate (2); cfg_data is written on the same clock edge.
// A character that completes an event passes the classifier register, the queue
// and the output register before out_valid rises.
// Throughput: one character per cycle while the output register is not stalled;
// each character is a single update of the parser state machine and its multiply-by-ten accumulator.
// When the receiver stalls, the output register holds its event, the two-entry
// queue and the classifier register fill, and then in_ready drops.
// Reset (synchronous, rst high) empties all stages, returns the parser to the
// idle state and loads the register reset values.
`include "leg_command_text_parser_macros.svh"

module leg_command_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [2:0]  leg_id,
  output logic [1:0]  actuator_id,
  output logic [23:0] position_value,
  output logic        position_given,
  output logic [23:0] power_value,
  output logic        power_given,
  output logic [23:0] rate_value,
  output logic [2:0]  error_code,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  lcp_pkg::cfg_t    cfg;
  lcp_pkg::cls_t    fr_cls;
  lcp_pkg::cls_t    q_cls;
  lcp_pkg::result_t result;
  logic             fr_valid;
  logic             fr_ready;
  logic             q_valid;
  logic             q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_limit <= lcp_pkg::POSITION_LIMIT_RESET;
      cfg.power_limit    <= lcp_pkg::POWER_LIMIT_RESET;
      cfg.default_rate   <= lcp_pkg::DEFAULT_RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lcp_pkg::REG_POSITION_LIMIT: cfg.position_limit <= cfg_data;
        lcp_pkg::REG_POWER_LIMIT:    cfg.power_limit    <= cfg_data;
        lcp_pkg::REG_DEFAULT_RATE:   cfg.default_rate   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_cls   (fr_cls)
  );

  lcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_cls),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cls)
  );

  lcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cls     (q_cls),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign event_kind     = result.kind;
  assign leg_id         = result.leg;
  assign actuator_id    = result.actuator;
  assign position_value = result.position;
  assign position_given = result.position_given;
  assign power_value    = result.power;
  assign power_given    = result.power_given;
  assign rate_value     = result.rate;
  assign error_code     = result.err;

  `LCP_ASSERT_IMPLY(a_error_code_iff_error,
    out_valid, ((event_kind == lcp_pkg::KIND_ERROR) == (error_code != lcp_pkg::ERR_NONE)))

  `LCP_ASSERT_IMPLY(a_move_ids_in_range,
    out_valid && event_kind == lcp_pkg::KIND_MOVE,
    leg_id != 3'd0 && leg_id <= 3'd4 && actuator_id != 2'd0)

  `LCP_ASSERT_IMPLY(a_other_events_no_ids,
    out_valid && event_kind != lcp_pkg::KIND_MOVE,
    leg_id == 3'd0 && actuator_id == 2'd0 && !position_given && !power_given)

  `LCP_ASSERT_NEXT(a_input_lands_in_front,
    in_valid && in_ready, fr_valid)

endmodule
